// ===== sv/distinct_random_sample_set_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the distinct random sample set
// Shared property wrappers, reset-qualified on the block clock.
// ----------------------------------------------------------------------------
`ifndef DISTINCT_RANDOM_SAMPLE_SET_ASSERT_SVH
`define DISTINCT_RANDOM_SAMPLE_SET_ASSERT_SVH

// implication checked in the cycle after the antecedent
`define DRSS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("drss assertion failed");

// implication checked in the same cycle
`define DRSS_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("drss assertion failed");

`endif

// ===== sv/drss_pkg.sv =====
// ----------------------------------------------------------------------------
// drss_pkg
// Shared constants and status codes of the distinct random sample set.
// ----------------------------------------------------------------------------
package drss_pkg;

  localparam int SET_DEPTH_DEF = 1024;
  localparam int WORD_W        = 32;
  localparam int OID_W         = 33;
  localparam int STATUS_W      = 3;

  typedef enum logic [STATUS_W-1:0] {
    ST_KEPT      = 3'd0,
    ST_DUP       = 3'd1,
    ST_NOTNEEDED = 3'd2,
    ST_TOOSMALL  = 3'd3,
    ST_EMITTED   = 3'd4,
    ST_NOTREADY  = 3'd5,
    ST_EXHAUSTED = 3'd6
  } status_t;

  // register indexes (byte address / 4)
  localparam logic [1:0] REG_BASE   = 2'd0;
  localparam logic [1:0] REG_TOTAL  = 2'd1;
  localparam logic [1:0] REG_SAMPLE = 2'd2;

  localparam logic CMD_OFFER = 1'b0;

endpackage

// ===== sv/distinct_random_sample_set.sv =====
// ----------------------------------------------------------------------------
// distinct_random_sample_set
// Sorted sampler of distinct ids over a configurable id range.
// ----------------------------------------------------------------------------
// Offer transactions (tuser = 0) carry a random word; it is reduced modulo
// total_count by a bit-serial restoring divider, offset by base_oid and
// inserted into a sorted on-chip store unless already there. The store is
// searched linearly and opened up by moving entries one slot up, all through
// its single read port. Offers and drains answered from the mode alone go
// straight to the output register. Drain transactions (tuser = 1) return
// the next sample id in ascending order: read from the store in set mode, or
// counted up past the kept ids, which are skipped, when the store holds the
// complement of the sample. Results go to an output register; the next
// transaction is taken while a result still waits there. Any write to the
// base, total or sample register clears the sample state. The store needs
// no clearing: only entries below the fill count are ever used.
// ----------------------------------------------------------------------------
module distinct_random_sample_set
  import drss_pkg::*;
#(
  parameter int SET_DEPTH = SET_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // input stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // [31:0] rand_word
  input  logic        s_tuser,   // [0] cmd
  // result stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // [32:0] sample_oid, [39:33] zero
  output logic [2:0]  m_tuser,   // [2:0] status
  output logic        m_tlast,
  // register port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int AW = (SET_DEPTH > 1) ? $clog2(SET_DEPTH) : 1;
  localparam int CW = $clog2(SET_DEPTH + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_DIV, S_SRCH_RD, S_SRCH_CMP, S_SHF_RD, S_SHF_WR, S_INS,
    S_DRN_RD, S_DRN_CMP, S_ANTI_RD, S_ANTI_CMP, S_OUT
  } state_t;

  state_t state;

  // configuration
  logic [31:0] base_oid, total_count, sample_size;

  // sample state
  logic [CW-1:0]  kept_count;
  logic [CW-1:0]  set_cursor;
  logic [31:0]    emit_position;
  logic [31:0]    emitted_count;

  // offer datapath
  logic [31:0]    rem;
  logic [31:0]    dvd;
  logic [4:0]     div_cnt;
  logic [OID_W-1:0] cand;
  logic [CW-1:0]  pos;
  logic [CW-1:0]  shf;

  // pending result
  status_t          pend_status;
  logic [OID_W-1:0] pend_oid;
  logic             pend_last;
  logic [OID_W-1:0] pend_oid_q;

  // store
  logic [OID_W-1:0] kept_ids [SET_DEPTH];
  logic [OID_W-1:0] rdata;
  logic [AW-1:0]    rd_addr;
  logic             we;
  logic [AW-1:0]    wr_addr;
  logic [OID_W-1:0] wr_data;

  // mode decode
  logic        mode_empty, mode_whole, mode_anti;
  logic [31:0] target;
  logic        too_small, set_full;

  assign mode_empty = (sample_size == '0);
  assign mode_whole = !mode_empty && (total_count <= sample_size);
  assign mode_anti  = !mode_empty && !mode_whole && (sample_size > (total_count >> 1));
  assign target     = mode_anti ? (total_count - sample_size) : sample_size;
  assign too_small  = target > 32'(SET_DEPTH);
  assign set_full   = 32'(kept_count) >= target;

  // divider step
  logic [32:0] div_r2;
  logic        div_ge;
  assign div_r2 = {rem, dvd[31]};
  assign div_ge = div_r2 >= {1'b0, total_count};

  logic [OID_W-1:0] anti_id;
  assign anti_id = {1'b0, base_oid} + {1'b0, emit_position};

  // register port
  logic cfg_wr;
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_comb begin
    case (paddr[3:2])
      REG_BASE:   prdata = base_oid;
      REG_TOTAL:  prdata = total_count;
      REG_SAMPLE: prdata = sample_size;
      default:    prdata = '0;
    endcase
  end

  // memory port control
  always_comb begin
    case (state)
      S_SRCH_RD: rd_addr = pos[AW-1:0];
      S_SHF_RD:  rd_addr = AW'(shf - CW'(1));
      default:   rd_addr = set_cursor[AW-1:0];
    endcase
    we      = (state == S_SHF_WR) || (state == S_INS);
    wr_addr = (state == S_INS) ? pos[AW-1:0] : shf[AW-1:0];
    wr_data = (state == S_INS) ? cand : rdata;
  end

  always_ff @(posedge clk) begin
    if (we) begin
      kept_ids[wr_addr] <= wr_data;
    end
    rdata <= kept_ids[rd_addr];
  end

  assign s_tready = (state == S_IDLE);
  assign m_tdata  = {{(40 - OID_W){1'b0}}, pend_oid_q};

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      base_oid      <= '0;
      total_count   <= '0;
      sample_size   <= '0;
      kept_count    <= '0;
      set_cursor    <= '0;
      emit_position <= '0;
      emitted_count <= '0;
      m_tvalid      <= 1'b0;
    end else begin
      // S_OUT handles the output register itself
      if (m_tvalid && m_tready && (state != S_OUT)) begin
        m_tvalid <= 1'b0;
      end
      if (cfg_wr && (paddr[3:2] <= REG_SAMPLE)) begin
        case (paddr[3:2])
          REG_BASE:   base_oid    <= pwdata;
          REG_TOTAL:  total_count <= pwdata;
          default:    sample_size <= pwdata;
        endcase
        kept_count    <= '0;
        set_cursor    <= '0;
        emit_position <= '0;
        emitted_count <= '0;
      end
      case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            pend_oid  <= '0;
            pend_last <= 1'b0;
            state     <= S_OUT;
            if (s_tuser == CMD_OFFER) begin
              if (mode_empty || mode_whole) begin
                pend_status <= ST_NOTNEEDED;
              end else if (too_small) begin
                pend_status <= ST_TOOSMALL;
              end else if (set_full) begin
                pend_status <= ST_NOTNEEDED;
              end else begin
                rem     <= '0;
                dvd     <= s_tdata;
                div_cnt <= '0;
                state   <= S_DIV;
              end
            end else if (mode_empty) begin
              pend_status <= ST_EXHAUSTED;
            end else if (mode_whole) begin
              if (emitted_count >= total_count) begin
                pend_status <= ST_EXHAUSTED;
              end else begin
                pend_status   <= ST_EMITTED;
                pend_oid      <= {1'b0, base_oid} + {1'b0, emitted_count};
                pend_last     <= (emitted_count + 32'd1) == total_count;
                emitted_count <= emitted_count + 32'd1;
              end
            end else if (too_small) begin
              pend_status <= ST_TOOSMALL;
            end else if (!set_full) begin
              pend_status <= ST_NOTREADY;
            end else if (!mode_anti) begin
              if (set_cursor >= kept_count) begin
                pend_status <= ST_EXHAUSTED;
              end else begin
                state <= S_DRN_RD;
              end
            end else if (emitted_count >= sample_size) begin
              pend_status <= ST_EXHAUSTED;
            end else begin
              state <= S_ANTI_RD;
            end
          end
        end
        S_DIV: begin
          rem     <= div_ge ? 32'(div_r2 - {1'b0, total_count}) : div_r2[31:0];
          dvd     <= dvd << 1;
          div_cnt <= div_cnt + 5'd1;
          if (div_cnt == 5'd31) begin
            pos   <= '0;
            state <= S_SRCH_RD;
          end
        end
        S_SRCH_RD: begin
          // the remainder is final here
          cand <= {1'b0, base_oid} + {1'b0, rem};
          if (pos == kept_count) begin
            shf   <= kept_count;
            state <= S_SHF_RD;
          end else begin
            state <= S_SRCH_CMP;
          end
        end
        S_SRCH_CMP: begin
          if (rdata < cand) begin
            pos   <= pos + CW'(1);
            state <= S_SRCH_RD;
          end else if (rdata == cand) begin
            pend_status <= ST_DUP;
            state       <= S_OUT;
          end else begin
            shf   <= kept_count;
            state <= S_SHF_RD;
          end
        end
        S_SHF_RD: begin
          state <= (shf == pos) ? S_INS : S_SHF_WR;
        end
        S_SHF_WR: begin
          shf   <= shf - CW'(1);
          state <= S_SHF_RD;
        end
        S_INS: begin
          kept_count  <= kept_count + CW'(1);
          pend_status <= ST_KEPT;
          state       <= S_OUT;
        end
        S_DRN_RD: begin
          state <= S_DRN_CMP;
        end
        S_DRN_CMP: begin
          pend_status <= ST_EMITTED;
          pend_oid    <= rdata;
          pend_last   <= (set_cursor + CW'(1)) == kept_count;
          set_cursor  <= set_cursor + CW'(1);
          state       <= S_OUT;
        end
        S_ANTI_RD: begin
          if (emit_position >= total_count) begin
            pend_status <= ST_EXHAUSTED;
            state       <= S_OUT;
          end else if (set_cursor < kept_count) begin
            state <= S_ANTI_CMP;
          end else begin
            pend_status   <= ST_EMITTED;
            pend_oid      <= anti_id;
            pend_last     <= (emitted_count + 32'd1) == sample_size;
            emitted_count <= emitted_count + 32'd1;
            emit_position <= emit_position + 32'd1;
            state         <= S_OUT;
          end
        end
        S_ANTI_CMP: begin
          emit_position <= emit_position + 32'd1;
          if (rdata == anti_id) begin
            set_cursor <= set_cursor + CW'(1);
            state      <= S_ANTI_RD;
          end else begin
            pend_status   <= ST_EMITTED;
            pend_oid      <= anti_id;
            pend_last     <= (emitted_count + 32'd1) == sample_size;
            emitted_count <= emitted_count + 32'd1;
            state         <= S_OUT;
          end
        end
        S_OUT: begin
          // wait for the output register to free up
          if (!m_tvalid || m_tready) begin
            m_tvalid   <= 1'b1;
            m_tuser    <= pend_status;
            pend_oid_q <= pend_oid;
            m_tlast    <= pend_last;
            state      <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== sv/drss_chk.sv =====
// ----------------------------------------------------------------------------
// drss_chk
// Port-level checks on the result stream and register port of the sample set.
// ----------------------------------------------------------------------------
`include "distinct_random_sample_set_assert.svh"

module drss_chk
  import drss_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [39:0] m_tdata,
  input logic [2:0]  m_tuser,
  input logic        m_tlast,
  input logic        pready
);

  // a stalled result stays offered
  `DRSS_ASSERT_NEXT(a_hold, m_tvalid && !m_tready, m_tvalid)
  // only emitted results carry an id
  `DRSS_ASSERT_NOW(a_oid_zero, m_tvalid && (m_tuser != ST_EMITTED), m_tdata == '0)
  // last only marks an emitted id
  `DRSS_ASSERT_NOW(a_last, m_tvalid && m_tlast, m_tuser == ST_EMITTED)
  `DRSS_ASSERT_NOW(a_pready, 1'b1, pready)

endmodule

bind distinct_random_sample_set drss_chk u_drss_chk (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .m_tlast  (m_tlast),
  .pready   (pready)
);
